// ===== sv/msp_pkg.sv =====
// ----------------------------------------------------------------------------
// msp_pkg
// Shared types and constants of the multi-slot periodic timer.
// ----------------------------------------------------------------------------
package msp_pkg;

  localparam int PERIOD_W   = 16;
  localparam int INTERVAL_W = 32;
  localparam int COUNT_W    = 32;
  localparam int TAG_W      = 16;
  localparam int SLOT_W     = 4;
  localparam int EVENT_W    = 2;
  localparam int PROD_W     = INTERVAL_W + PERIOD_W;
  localparam int REM_STEPS  = INTERVAL_W;
  localparam int REM_CNT_W  = $clog2(REM_STEPS);

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd10;

  localparam logic [EVENT_W-1:0] EV_REG_OK  = 2'd0;
  localparam logic [EVENT_W-1:0] EV_REG_REJ = 2'd1;
  localparam logic [EVENT_W-1:0] EV_FIRED   = 2'd2;

  localparam logic KIND_TICK = 1'b0;

  typedef struct packed {
    logic [INTERVAL_W-1:0] interval;
    logic [COUNT_W-1:0]    repeat_limit;
    logic [COUNT_W-1:0]    tick_count;
    logic [COUNT_W-1:0]    fire_count;
    logic [TAG_W-1:0]      tag;
  } slot_entry_t;

  typedef struct packed {
    logic done;
    logic rem_zero;
  } rem_status_t;

endpackage

// ===== sv/msp_rem.sv =====
// ----------------------------------------------------------------------------
// msp_rem
// Restoring remainder unit: interval modulo period, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module msp_rem import msp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [INTERVAL_W-1:0] dividend,
  input  logic [PERIOD_W-1:0]   divisor,
  output rem_status_t           status
);

  logic [PERIOD_W-1:0]   rem_r;
  logic [PERIOD_W-1:0]   rem_nxt;
  logic [PERIOD_W-1:0]   dsr_r;
  logic [INTERVAL_W-1:0] dvd_r;
  logic [REM_CNT_W-1:0]  cnt_r;
  logic                  run_r;
  logic                  done_r;
  logic [PERIOD_W:0]     shifted;
  logic [PERIOD_W:0]     diff;

  assign shifted = {rem_r, dvd_r[INTERVAL_W-1]};
  assign diff    = shifted - {1'b0, dsr_r};

  always_comb begin
    if (shifted >= {1'b0, dsr_r}) begin
      rem_nxt = diff[PERIOD_W-1:0];
    end else begin
      rem_nxt = shifted[PERIOD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      run_r  <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (run_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == REM_CNT_W'(REM_STEPS - 1)) begin
        run_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      dsr_r <= divisor;
      dvd_r <= dividend;
    end else if (run_r) begin
      rem_r <= rem_nxt;
      dvd_r <= {dvd_r[INTERVAL_W-2:0], 1'b0};
    end
  end

  assign status.done     = done_r;
  assign status.rem_zero = (rem_r == '0);

endmodule

// ===== sv/multi_slot_periodic_timer_top.sv =====
// ----------------------------------------------------------------------------
// multi_slot_periodic_timer_top
// Table of timer slots in one synchronous memory, advanced by tick commands.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; busy falls as its last
// result goes out. A register command scans the valid bits one slot a cycle
// while the 32-step remainder unit checks the interval against the period, and
// busy stays high until both are done. A tick command walks the table one slot
// at a time: a free slot passes only through ST_TCHK, and a valid one also
// through ST_TRD and ST_TCMP (memory read, multiply, compare and write-back).
// Each result is shown for one cycle on out_valid and the receiver cannot
// stall it; a firing is held until the next firing or the end of the walk so
// that out_last can mark the final result of a tick. A quiet tick gives no
// result.
module multi_slot_periodic_timer_top import msp_pkg::*; #(
  parameter int NUM_SLOTS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [PERIOD_W-1:0]   cfg_wr_data,
  input  logic                  start,
  output logic                  busy,
  input  logic                  in_kind,
  input  logic [INTERVAL_W-1:0] in_interval_ms,
  input  logic [COUNT_W-1:0]    in_repeat_count,
  input  logic [TAG_W-1:0]      in_tag,
  input  logic                  in_has_handler,
  output logic                  out_valid,
  output logic [EVENT_W-1:0]    out_event_res,
  output logic [SLOT_W-1:0]     out_slot,
  output logic [TAG_W-1:0]      out_tag_res,
  output logic                  out_expired,
  output logic                  out_last
);

  localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CNT_W = $clog2(NUM_SLOTS + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REG,
    ST_TCHK,
    ST_TRD,
    ST_TCMP
  } state_t;

  state_t                state_r;
  logic [PERIOD_W-1:0]   period_r;
  logic [NUM_SLOTS-1:0]  valid_r;
  logic [CNT_W-1:0]      cnt_r;
  logic                  found_r;

  logic [INTERVAL_W-1:0] req_interval_r;
  logic [COUNT_W-1:0]    req_repeat_r;
  logic [TAG_W-1:0]      req_tag_r;
  logic                  req_hnd_r;

  slot_entry_t           mem [NUM_SLOTS];
  slot_entry_t           rd_data_r;
  slot_entry_t           wr_data;
  logic                  mem_we;
  logic                  mem_re;

  logic [COUNT_W-1:0]    tick_inc_r;
  logic [COUNT_W-1:0]    tick_sum;
  logic [PROD_W-1:0]     prod_r;

  logic                  pend_r;
  logic [SLOT_W-1:0]     pend_slot_r;
  logic [TAG_W-1:0]      pend_tag_r;
  logic                  pend_exp_r;

  logic                  out_valid_r;
  logic [EVENT_W-1:0]    out_event_r;
  logic [SLOT_W-1:0]     out_slot_r;
  logic [TAG_W-1:0]      out_tag_r;
  logic                  out_exp_r;
  logic                  out_last_r;

  logic [IDX_W-1:0]      idx;
  logic [IDX_W+SLOT_W-1:0] slot_ext;
  logic [SLOT_W-1:0]     slot4;
  logic                  scan_end;
  logic                  scan_done;
  logic                  reg_ok;
  logic                  reg_fin;
  logic                  fire;
  logic [COUNT_W-1:0]    fire_inc;
  logic                  freed;
  logic                  accept;
  rem_status_t           rem_st;

  assign accept    = start && (state_r == ST_IDLE);
  assign idx       = cnt_r[IDX_W-1:0];
  assign slot_ext  = {{SLOT_W{1'b0}}, idx};
  assign slot4     = slot_ext[SLOT_W-1:0];
  assign scan_end  = (cnt_r == CNT_W'(NUM_SLOTS));
  assign scan_done = found_r || scan_end;
  assign reg_fin   = (state_r == ST_REG) && scan_done && rem_st.done;
  assign reg_ok    = found_r && req_hnd_r && (period_r != '0) && rem_st.rem_zero;

  assign tick_sum = rd_data_r.tick_count + 1'b1;
  assign fire     = prod_r >= {{PERIOD_W{1'b0}}, rd_data_r.interval};
  assign fire_inc = rd_data_r.fire_count + 1'b1;
  assign freed    = fire && (rd_data_r.repeat_limit != '0) &&
                    (fire_inc >= rd_data_r.repeat_limit);

  msp_rem u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (accept && (in_kind != KIND_TICK)),
    .dividend (in_interval_ms),
    .divisor  (period_r),
    .status   (rem_st)
  );

  // write of a new slot entry on registration, read-modify-write on a tick
  always_comb begin
    mem_re  = (state_r == ST_TCHK) && !scan_end && valid_r[idx];
    mem_we  = 1'b0;
    wr_data = rd_data_r;
    if (reg_fin && reg_ok) begin
      mem_we               = 1'b1;
      wr_data.interval     = req_interval_r;
      wr_data.repeat_limit = req_repeat_r;
      wr_data.tick_count   = '0;
      wr_data.fire_count   = '0;
      wr_data.tag          = req_tag_r;
    end else if (state_r == ST_TCMP) begin
      mem_we = 1'b1;
      if (fire) begin
        wr_data.tick_count = '0;
        wr_data.fire_count = fire_inc;
      end else begin
        wr_data.tick_count = tick_inc_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[idx] <= wr_data;
    end
    if (mem_re) begin
      rd_data_r <= mem[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= PERIOD_RESET;
    end else if (cfg_wr_en) begin
      period_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_TRD) begin
      tick_inc_r <= tick_sum;
      prod_r     <= PROD_W'(tick_sum) * PROD_W'(period_r);
    end
    if (accept) begin
      req_interval_r <= in_interval_ms;
      req_repeat_r   <= in_repeat_count;
      req_tag_r      <= in_tag;
      req_hnd_r      <= in_has_handler;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      valid_r     <= '0;
      cnt_r       <= '0;
      found_r     <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          cnt_r   <= '0;
          found_r <= 1'b0;
          pend_r  <= 1'b0;
          if (accept) begin
            state_r <= (in_kind == KIND_TICK) ? ST_TCHK : ST_REG;
          end
        end
        ST_REG: begin
          if (!scan_done) begin
            if (!valid_r[idx]) begin
              found_r <= 1'b1;
            end else begin
              cnt_r <= cnt_r + 1'b1;
            end
          end
          if (reg_fin) begin
            out_valid_r <= 1'b1;
            out_tag_r   <= req_tag_r;
            out_exp_r   <= 1'b0;
            out_last_r  <= 1'b1;
            if (reg_ok) begin
              valid_r[idx] <= 1'b1;
              out_event_r  <= EV_REG_OK;
              out_slot_r   <= slot4;
            end else begin
              out_event_r <= EV_REG_REJ;
              out_slot_r  <= '0;
            end
            state_r <= ST_IDLE;
          end
        end
        ST_TCHK: begin
          if (scan_end) begin
            if (pend_r) begin
              out_valid_r <= 1'b1;
              out_event_r <= EV_FIRED;
              out_slot_r  <= pend_slot_r;
              out_tag_r   <= pend_tag_r;
              out_exp_r   <= pend_exp_r;
              out_last_r  <= 1'b1;
            end
            state_r <= ST_IDLE;
          end else if (valid_r[idx]) begin
            state_r <= ST_TRD;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        ST_TRD: begin
          state_r <= ST_TCMP;
        end
        ST_TCMP: begin
          if (fire) begin
            if (pend_r) begin
              out_valid_r <= 1'b1;
              out_event_r <= EV_FIRED;
              out_slot_r  <= pend_slot_r;
              out_tag_r   <= pend_tag_r;
              out_exp_r   <= pend_exp_r;
              out_last_r  <= 1'b0;
            end
            pend_r      <= 1'b1;
            pend_slot_r <= slot4;
            pend_tag_r  <= rd_data_r.tag;
            pend_exp_r  <= freed;
          end
          if (freed) begin
            valid_r[idx] <= 1'b0;
          end
          cnt_r   <= cnt_r + 1'b1;
          state_r <= ST_TCHK;
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy          = (state_r != ST_IDLE);
  assign out_valid     = out_valid_r;
  assign out_event_res = out_event_r;
  assign out_slot      = out_slot_r;
  assign out_tag_res   = out_tag_r;
  assign out_expired   = out_exp_r;
  assign out_last      = out_last_r;

endmodule

// ===== tb/sv/tb_multi_slot_periodic_timer_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_multi_slot_periodic_timer_top
// Self-checking bench for the multi-slot periodic timer.
// ----------------------------------------------------------------------------
// Register and tick commands go in through the start/busy handshake. A timer
// table model inside the bench computes the events each accepted command
// should produce. Each strobed event is compared field by field against the
// oldest pending one. Directed tests come first: filling the table, rejected
// registrations, repeat expiry and the period extremes. Random traffic then
// runs over several tick periods with random idle gaps between commands.
// ----------------------------------------------------------------------------
module tb_multi_slot_periodic_timer_top;
  import msp_pkg::*;

  localparam int   NUM_SLOTS  = 16;
  localparam int   IDLE_LIMIT = 4000;
  localparam logic KIND_REG   = ~KIND_TICK;

  typedef struct packed {
    logic [EVENT_W-1:0] ev;
    logic [SLOT_W-1:0]  slot;
    logic [TAG_W-1:0]   tag;
    logic               expired;
    logic               last;
  } timer_event_t;

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  cfg_wr_en = 1'b0;
  logic [PERIOD_W-1:0]   cfg_wr_data = '0;
  logic                  start = 1'b0;
  logic                  busy;
  logic                  in_kind = KIND_TICK;
  logic [INTERVAL_W-1:0] in_interval_ms = '0;
  logic [COUNT_W-1:0]    in_repeat_count = '0;
  logic [TAG_W-1:0]      in_tag = '0;
  logic                  in_has_handler = 1'b0;
  logic                  out_valid;
  logic [EVENT_W-1:0]    out_event_res;
  logic [SLOT_W-1:0]     out_slot;
  logic [TAG_W-1:0]      out_tag_res;
  logic                  out_expired;
  logic                  out_last;

  // timer table model
  logic [PERIOD_W-1:0]   tm_period = PERIOD_RESET;
  logic                  tm_valid [NUM_SLOTS];
  logic [INTERVAL_W-1:0] tm_interval [NUM_SLOTS];
  logic [COUNT_W-1:0]    tm_limit [NUM_SLOTS];
  logic [COUNT_W-1:0]    tm_ticks [NUM_SLOTS];
  logic [COUNT_W-1:0]    tm_fires [NUM_SLOTS];
  logic [TAG_W-1:0]      tm_tag [NUM_SLOTS];

  timer_event_t pending_events [$];
  timer_event_t got_event;
  timer_event_t want_event;

  int err_count   = 0;
  int cmd_count   = 0;
  int armed_count = 0;
  int refused_count = 0;
  int fired_count = 0;
  int freed_count = 0;
  int gap_cap     = 11;
  int idle_cycles = 0;

  multi_slot_periodic_timer_top #(
    .NUM_SLOTS(NUM_SLOTS)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .start          (start),
    .busy           (busy),
    .in_kind        (in_kind),
    .in_interval_ms (in_interval_ms),
    .in_repeat_count(in_repeat_count),
    .in_tag         (in_tag),
    .in_has_handler (in_has_handler),
    .out_valid      (out_valid),
    .out_event_res  (out_event_res),
    .out_slot       (out_slot),
    .out_tag_res    (out_tag_res),
    .out_expired    (out_expired),
    .out_last       (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      tm_valid[i] = 1'b0;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    err_count++;
  endtask

  // expected events of one accepted command
  function automatic void advance_timer_table(input logic kind, input logic [31:0] ivl,
                                              input logic [31:0] rpt, input logic [15:0] tg,
                                              input logic hnd);
    int free_slot;
    int first_new;
    logic [63:0] elapsed;
    logic freed;
    timer_event_t e;
    free_slot = -1;
    if (kind == KIND_REG) begin
      for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
        if (!tm_valid[i]) free_slot = i;
      end
      e.tag = tg;
      e.expired = 1'b0;
      e.last = 1'b1;
      if (free_slot < 0 || !hnd || tm_period == '0 || (ivl % tm_period) != 0) begin
        e.ev = EV_REG_REJ;
        e.slot = '0;
        refused_count++;
      end else begin
        tm_valid[free_slot] = 1'b1;
        tm_interval[free_slot] = ivl;
        tm_limit[free_slot] = rpt;
        tm_ticks[free_slot] = '0;
        tm_fires[free_slot] = '0;
        tm_tag[free_slot] = tg;
        e.ev = EV_REG_OK;
        e.slot = free_slot[SLOT_W-1:0];
        armed_count++;
      end
      pending_events.push_back(e);
      return;
    end
    first_new = pending_events.size();
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (tm_valid[i]) begin
        tm_ticks[i] = tm_ticks[i] + 1;
        elapsed = {32'd0, tm_ticks[i]} * {48'd0, tm_period};
        if (elapsed >= {32'd0, tm_interval[i]}) begin
          tm_ticks[i] = '0;
          tm_fires[i] = tm_fires[i] + 1;
          freed = (tm_limit[i] != '0) && (tm_fires[i] >= tm_limit[i]);
          if (freed) begin
            tm_valid[i] = 1'b0;
            freed_count++;
          end
          e.ev = EV_FIRED;
          e.slot = i[SLOT_W-1:0];
          e.tag = tm_tag[i];
          e.expired = freed;
          e.last = 1'b0;
          pending_events.push_back(e);
          fired_count++;
        end
      end
    end
    if (pending_events.size() > first_new) begin
      pending_events[pending_events.size() - 1].last = 1'b1;
    end
  endfunction

  function automatic int next_gap();
    return $urandom_range(0, gap_cap);
  endfunction

  function automatic int free_slot_count();
    int n;
    n = 0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (!tm_valid[i]) n++;
    end
    return n;
  endfunction

  task automatic send_cmd(input logic kind, input logic [31:0] ivl, input logic [31:0] rpt,
                          input logic [15:0] tg, input logic hnd, input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_kind <= kind;
    in_interval_ms <= ivl;
    in_repeat_count <= rpt;
    in_tag <= tg;
    in_has_handler <= hnd;
    do @(posedge clk); while (busy);
    advance_timer_table(kind, ivl, rpt, tg, hnd);
    cmd_count++;
  endtask

  task automatic tick(input int gap);
    send_cmd(KIND_TICK, $urandom(), $urandom(), 16'($urandom_range(0, 65535)),
             1'($urandom_range(0, 1)), gap);
  endtask

  // hold off until every expected event is out and the table walk is done
  task automatic wait_for_quiet();
    start <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (3 * NUM_SLOTS + 4) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic set_period(input logic [PERIOD_W-1:0] value);
    wait_for_quiet();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    tm_period = value;
  endtask

  // every slot armed, one more registration refused, then a tick that fires 14
  task automatic test_table_fill();
    gap_cap = 11;
    send_cmd(KIND_REG, 32'd30, 32'd2, 16'hFFFF, 1'b1, next_gap());
    send_cmd(KIND_REG, 32'hFFFF_FFFA, 32'hFFFF_FFFF, 16'h0000, 1'b1, next_gap());
    send_cmd(KIND_REG, 32'd0, 32'd0, 16'($urandom_range(0, 65535)), 1'b1, next_gap());
    for (int i = 3; i < NUM_SLOTS; i++) begin
      send_cmd(KIND_REG, 32'd0, 32'd1, 16'($urandom_range(0, 65535)), 1'b1, next_gap());
    end
    send_cmd(KIND_REG, 32'd10, 32'd1, 16'h1234, 1'b1, next_gap());
    tick(next_gap());
  endtask

  task automatic test_rejects_and_expiry();
    send_cmd(KIND_REG, 32'd10, 32'd1, 16'hA5A5, 1'b0, next_gap());
    send_cmd(KIND_REG, 32'd25, 32'd1, 16'h5A5A, 1'b1, next_gap());
    send_cmd(KIND_REG, 32'd20, 32'd1, 16'h0F0F, 1'b1, next_gap());
    tick(next_gap());
    tick(next_gap());
  endtask

  task automatic test_period_extremes();
    set_period(16'd0);
    send_cmd(KIND_REG, 32'd0, 32'd1, 16'h00FF, 1'b1, next_gap());
    tick(next_gap());
    set_period(16'hFFFF);
    send_cmd(KIND_REG, 32'd65535, 32'd1, 16'hFF00, 1'b1, next_gap());
    tick(next_gap());
  endtask

  task automatic send_random_cmd();
    int r;
    int spare;
    logic [31:0] ivl;
    logic [31:0] rpt;
    spare = free_slot_count();
    if ($urandom_range(0, 99) >= 40) begin
      tick(next_gap());
      return;
    end
    r = $urandom_range(0, 99);
    if (r < 6 && spare > 6) begin
      ivl = $urandom();
    end else if (r < 12 && tm_period > 1) begin
      ivl = {16'd0, tm_period} * $urandom_range(0, 8) + $urandom_range(1, tm_period - 1);
    end else if (r < 12) begin
      ivl = (tm_period == '0) ? $urandom() : $urandom_range(0, 8);
    end else begin
      ivl = {16'd0, tm_period} * $urandom_range(0, 8);
    end
    r = $urandom_range(0, 99);
    if (r < 4 && spare > 6) rpt = '0;
    else if (r < 8 && spare > 6) rpt = $urandom();
    else rpt = $urandom_range(1, 4);
    send_cmd(KIND_REG, ivl, rpt, 16'($urandom_range(0, 65535)), $urandom_range(0, 11) != 0,
             next_gap());
  endtask

  task automatic test_random_traffic();
    logic [PERIOD_W-1:0] periods [7];
    int counts [7];
    periods = '{16'd1, 16'd3, 16'd7, 16'd10, 16'($urandom_range(11, 60)), 16'hFFFF, 16'd0};
    counts = '{68, 68, 68, 68, 68, 68, 20};
    for (int p = 0; p < 7; p++) begin
      set_period(periods[p]);
      for (int n = 0; n < counts[p]; n++) begin
        if (n % 25 == 0) begin
          case ($urandom_range(0, 3))
            0: gap_cap = 0;
            1: gap_cap = 4;
            default: gap_cap = 11;
          endcase
        end
        send_random_cmd();
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      got_event = '{out_event_res, out_slot, out_tag_res, out_expired, out_last};
      if (pending_events.size() == 0) begin
        report_mismatch($sformatf("unexpected event %0d slot %0d tag %h",
                                  out_event_res, out_slot, out_tag_res));
      end else begin
        want_event = pending_events.pop_front();
        if (got_event.ev !== want_event.ev || got_event.slot !== want_event.slot ||
            got_event.tag !== want_event.tag || got_event.expired !== want_event.expired ||
            got_event.last !== want_event.last) begin
          report_mismatch($sformatf(
            "ev/slot/tag/exp/last got %0d/%0d/%h/%0b/%0b want %0d/%0d/%h/%0b/%0b",
            got_event.ev, got_event.slot, got_event.tag, got_event.expired, got_event.last,
            want_event.ev, want_event.slot, want_event.tag, want_event.expired,
            want_event.last));
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_valid) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog expired with %0d events pending", pending_events.size());
        $display("multi_slot_periodic_timer_top: mismatch");
        $finish;
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_table_fill();
    test_rejects_and_expiry();
    test_period_extremes();
    test_random_traffic();
    wait_for_quiet();
    if (pending_events.size() != 0) begin
      report_mismatch($sformatf("%0d events never came", pending_events.size()));
    end
    $display("%0d commands: %0d timers armed, %0d refused, %0d firings, %0d slots freed",
             cmd_count, armed_count, refused_count, fired_count, freed_count);
    $display("periods swept from 0 to 65535 with a full table and %0d errors", err_count);
    if (err_count == 0) begin
      $display("multi_slot_periodic_timer_top: match");
    end else begin
      $display("multi_slot_periodic_timer_top: mismatch");
    end
    $finish;
  end

endmodule
